/* hw/rtl/frfifo_pkg.sv */
// shared types, codes and constants of the framed ring fifo
package frfifo_pkg;

	// field widths
	localparam int OP_W       = 3;
	localparam int FLEN_W     = 16;
	localparam int BYTE_W     = 8;
	localparam int LIMIT_W    = 15;
	localparam int STATUS_W   = 2;
	localparam int COUNT_W    = 13;
	localparam int QL_W       = 13;
	localparam int TMO_W      = 16;
	localparam int LEN_W      = 17;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	// defaults and limits
	localparam int RING_DEPTH_DEFAULT = 4096;
	localparam logic [QL_W-1:0]  QUEUE_LENGTH_MIN   = 13'd3;
	localparam logic [QL_W-1:0]  QUEUE_LENGTH_RESET = 13'd4096;
	localparam logic [TMO_W-1:0] TIMEOUT_RESET      = 16'd2000;
	localparam logic [TMO_W-1:0] AGE_MAX            = 16'hFFFF;
	localparam logic [LEN_W-1:0] HDR_BYTES          = 17'd2;

	// operation codes
	typedef enum logic [OP_W-1:0] {
		OP_WRITE_START = 3'd0,
		OP_WRITE_BYTE  = 3'd1,
		OP_READ_START  = 3'd2,
		OP_READ_BYTE   = 3'd3,
		OP_TICK        = 3'd4
	} op_t;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_OK     = 2'd0,
		ST_REJECT = 2'd1,
		ST_NONE   = 2'd2
	} status_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_QUEUE_LENGTH  = 1'd0,
		CFG_TIMEOUT_TICKS = 1'd1
	} cfg_idx_t;

	// commands from the controller to the datapath
	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_SIMPLE,
		CMD_WALK_INIT,
		CMD_RD_POS,
		CMD_RD_POS1,
		CMD_STEP,
		CMD_HDR0,
		CMD_HDR1,
		CMD_FINISH
	} cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic need_walk;
		logic walk_go;
		logic start_hdr;
		logic out_free;
	} dp_status_t;

	typedef struct packed {
		logic [OP_W-1:0]    operation;
		logic [FLEN_W-1:0]  frame_length;
		logic [BYTE_W-1:0]  data_in;
		logic [LIMIT_W-1:0] read_limit;
	} item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [BYTE_W-1:0]   data_out;
		logic [COUNT_W-1:0]  byte_count;
		logic                last_byte;
		logic                store_cleared;
	} result_t;

endpackage

/* hw/rtl/frfifo_ifs.sv */
// handshake channel interfaces of the framed ring fifo

// input item channel
interface frfifo_item_if import frfifo_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [OP_W-1:0]     operation;
	logic [FLEN_W-1:0]   frame_length;
	logic [BYTE_W-1:0]   data_in;
	logic [LIMIT_W-1:0]  read_limit;

	modport source (output valid, output operation, output frame_length, output data_in,
		output read_limit, input ready);
	modport sink (input valid, input operation, input frame_length, input data_in,
		input read_limit, output ready);
endinterface

// result channel
interface frfifo_result_if import frfifo_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [BYTE_W-1:0]   data_out;
	logic [COUNT_W-1:0]  byte_count;
	logic                last_byte;
	logic                store_cleared;

	modport source (output valid, output status, output data_out, output byte_count,
		output last_byte, output store_cleared, input ready);
	modport sink (input valid, input status, input data_out, input byte_count,
		input last_byte, input store_cleared, output ready);
endinterface

// configuration write channel
interface frfifo_cfg_if import frfifo_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/frfifo_ctrl.sv */
// controller state machine sequencing one transaction at a time
module frfifo_ctrl import frfifo_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_ready,
	input  dp_status_t st,
	output cmd_t       cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_CHECK,
		S_HI,
		S_LO,
		S_HDR1
	} state_t;

	state_t state_q;
	state_t state_n;

	// next state and command decode
	always_comb begin
		state_n    = state_q;
		cmd        = CMD_NONE;
		item_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd     = CMD_LOAD;
					state_n = S_EXEC;
				end
			end
			S_EXEC: begin
				if (st.need_walk) begin
					cmd     = CMD_WALK_INIT;
					state_n = S_CHECK;
				end else if (st.out_free) begin
					cmd     = CMD_SIMPLE;
					state_n = S_IDLE;
				end
			end
			S_CHECK: begin
				if (st.walk_go) begin
					cmd     = CMD_RD_POS;
					state_n = S_HI;
				end else if (st.start_hdr) begin
					cmd     = CMD_HDR0;
					state_n = S_HDR1;
				end else if (st.out_free) begin
					cmd     = CMD_FINISH;
					state_n = S_IDLE;
				end
			end
			S_HI: begin
				cmd     = CMD_RD_POS1;
				state_n = S_LO;
			end
			S_LO: begin
				cmd     = CMD_STEP;
				state_n = S_CHECK;
			end
			S_HDR1: begin
				if (st.out_free) begin
					cmd     = CMD_HDR1;
					state_n = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

endmodule

/* hw/rtl/frfifo_dp.sv */
// datapath: ring memory, pointers, header walk and result register
module frfifo_dp import frfifo_pkg::*; #(
	parameter int RING_DEPTH = RING_DEPTH_DEFAULT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	output dp_status_t            st,
	input  item_t                 item_data,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_value,
	input  logic                  res_ready,
	output logic                  res_valid,
	output result_t               res
);

	localparam int PTR_W = $clog2(RING_DEPTH);
	localparam int CNT_W = PTR_W + 1;
	localparam logic [CNT_W-1:0] QL_RESET = (RING_DEPTH < int'(QUEUE_LENGTH_RESET)) ?
		CNT_W'(RING_DEPTH) : CNT_W'(QUEUE_LENGTH_RESET);
	localparam logic [LEN_W-1:0] DEPTH_L = LEN_W'(RING_DEPTH);

	// configuration
	logic [CNT_W-1:0]   ql_q;
	logic [TMO_W-1:0]   tmo_q;
	// store state
	logic [PTR_W-1:0]   head_q;
	logic [PTR_W-1:0]   tail_q;
	logic [CNT_W-1:0]   fill_q;
	logic [FLEN_W-1:0]  wr_left_q;
	logic [CNT_W-1:0]   rd_left_q;
	logic [TMO_W-1:0]   age_q;
	// latched transaction
	logic [OP_W-1:0]    op_q;
	logic [FLEN_W-1:0]  flen_q;
	logic [BYTE_W-1:0]  din_q;
	logic [LIMIT_W-1:0] limit_q;
	// header walk
	logic [PTR_W-1:0]   pos_q;
	logic [CNT_W-1:0]   f_q;
	logic [LIMIT_W-1:0] left_q;
	logic [CNT_W-1:0]   count_q;
	logic               cleared_q;
	logic [BYTE_W-1:0]  hdr_hi_q;
	// memory
	logic [BYTE_W-1:0]  ring_q [RING_DEPTH];
	logic [BYTE_W-1:0]  rdata_q;
	// result register
	logic               res_valid_q;
	result_t            res_q;

	logic               busy;
	logic               is_write;
	logic [LEN_W-1:0]   need;
	logic [LEN_W-1:0]   room;
	logic [LEN_W-1:0]   f_l;
	logic [LEN_W-1:0]   hdr_len;
	logic               hdr_fits;
	logic [CNT_W-1:0]   fl_c;
	logic [PTR_W-1:0]   pos_adv;
	logic [PTR_W-1:0]   pos1;
	logic [PTR_W-1:0]   tail_inc;
	logic [PTR_W-1:0]   head_inc;
	logic               fill_lt_limit;
	logic [TMO_W-1:0]   age_inc;
	logic               expire;
	logic [PTR_W-1:0]   rd_addr;
	logic               we;
	logic [BYTE_W-1:0]  wdata;
	logic               emit;
	result_t            res_n;
	logic [LEN_W-1:0]   qv;
	logic [CNT_W-1:0]   ql_new;
	logic [TMO_W-1:0]   tmo_new;

	// pointer advance modulo the queue length, p below ql and d at most ql
	function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] p,
		input logic [CNT_W-1:0] d, input logic [CNT_W-1:0] ql);
		logic [CNT_W-1:0] s;
		s = {1'b0, p} + d;
		if (s >= ql) begin
			s = s - ql;
		end
		return s[PTR_W-1:0];
	endfunction

	// derived values
	always_comb begin
		busy          = (wr_left_q != '0) || (rd_left_q != '0);
		is_write      = (op_q == OP_WRITE_START);
		need          = {1'b0, flen_q} + HDR_BYTES;
		room          = LEN_W'(ql_q - f_q);
		f_l           = LEN_W'(f_q);
		hdr_len       = {1'b0, hdr_hi_q, rdata_q} + HDR_BYTES;
		hdr_fits      = (hdr_len <= f_l);
		fl_c          = hdr_len[CNT_W-1:0];
		pos_adv       = ptr_add(pos_q, fl_c, ql_q);
		pos1          = ptr_add(pos_q, CNT_W'(1), ql_q);
		tail_inc      = ptr_add(tail_q, CNT_W'(1), ql_q);
		head_inc      = ptr_add(head_q, CNT_W'(1), ql_q);
		fill_lt_limit = (LEN_W'(fill_q) < LEN_W'(limit_q));
		age_inc       = (age_q == AGE_MAX) ? age_q : age_q + 16'd1;
		expire        = (age_inc >= tmo_q);
		emit          = (cmd == CMD_SIMPLE) || (cmd == CMD_FINISH) || (cmd == CMD_HDR1);
	end

	// status to the controller
	always_comb begin
		st.need_walk = !busy && (is_write ||
			((op_q == OP_READ_START) && (fill_q != '0) && !fill_lt_limit));
		st.walk_go   = is_write ? ((room < need) && (f_l > HDR_BYTES)) :
			((left_q != '0) && (f_q != '0));
		st.start_hdr = is_write && (room >= need);
		st.out_free  = !res_valid_q || res_ready;
	end

	// configuration values, queue length clamped into range
	always_comb begin
		qv = LEN_W'(cfg_value[QL_W-1:0]);
		if (qv < LEN_W'(QUEUE_LENGTH_MIN)) begin
			ql_new = CNT_W'(QUEUE_LENGTH_MIN);
		end else if (qv > DEPTH_L) begin
			ql_new = CNT_W'(RING_DEPTH);
		end else begin
			ql_new = CNT_W'(qv);
		end
		tmo_new = (cfg_value == '0) ? 16'd1 : cfg_value;
	end

	// memory port selection
	always_comb begin
		case (cmd)
			CMD_RD_POS:  rd_addr = pos_q;
			CMD_RD_POS1: rd_addr = pos1;
			default:     rd_addr = head_q;
		endcase
		we    = 1'b0;
		wdata = din_q;
		case (cmd)
			CMD_SIMPLE: we = (op_q == OP_WRITE_BYTE) && (wr_left_q != '0);
			CMD_HDR0: begin
				we    = 1'b1;
				wdata = flen_q[FLEN_W-1:BYTE_W];
			end
			CMD_HDR1: begin
				we    = 1'b1;
				wdata = flen_q[BYTE_W-1:0];
			end
			default: we = 1'b0;
		endcase
	end

	// ring memory, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			ring_q[tail_q] <= wdata;
		end
		rdata_q <= ring_q[rd_addr];
	end

	// result of the current transaction
	always_comb begin
		res_n.status        = ST_NONE;
		res_n.data_out      = '0;
		res_n.byte_count    = '0;
		res_n.last_byte     = 1'b0;
		res_n.store_cleared = 1'b0;
		case (cmd)
			CMD_SIMPLE: begin
				case (op_q)
					OP_WRITE_BYTE: begin
						if (wr_left_q != '0) begin
							res_n.status = ST_OK;
						end
					end
					OP_READ_START: begin
						if (!busy && (fill_q != '0)) begin
							res_n.status     = ST_OK;
							res_n.byte_count = COUNT_W'(fill_q);
						end
					end
					OP_READ_BYTE: begin
						if (rd_left_q != '0) begin
							res_n.status    = ST_OK;
							res_n.data_out  = rdata_q;
							res_n.last_byte = (rd_left_q == CNT_W'(1));
						end
					end
					OP_TICK: begin
						res_n.status        = ST_OK;
						res_n.store_cleared = expire && ((fill_q != '0) || busy);
					end
					default: res_n.status = ST_NONE;
				endcase
			end
			CMD_FINISH: begin
				res_n.store_cleared = cleared_q;
				if (is_write) begin
					res_n.status = ST_REJECT;
				end else begin
					res_n.status     = ST_OK;
					res_n.byte_count = COUNT_W'(count_q);
				end
			end
			CMD_HDR1: begin
				res_n.status        = ST_OK;
				res_n.store_cleared = cleared_q;
			end
			default: res_n.status = ST_NONE;
		endcase
	end

	// store state, configuration and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ql_q        <= QL_RESET;
			tmo_q       <= TIMEOUT_RESET;
			head_q      <= '0;
			tail_q      <= '0;
			fill_q      <= '0;
			wr_left_q   <= '0;
			rd_left_q   <= '0;
			age_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			case (cmd)
				CMD_SIMPLE: begin
					case (op_q)
						OP_WRITE_BYTE: begin
							if (wr_left_q != '0) begin
								tail_q    <= tail_inc;
								wr_left_q <= wr_left_q - 16'd1;
								age_q     <= '0;
							end
						end
						OP_READ_START: begin
							// whole fill below the limit goes out
							if (!busy && (fill_q != '0)) begin
								fill_q    <= '0;
								rd_left_q <= fill_q;
							end
						end
						OP_READ_BYTE: begin
							if (rd_left_q != '0) begin
								head_q    <= head_inc;
								rd_left_q <= rd_left_q - CNT_W'(1);
							end
						end
						OP_TICK: begin
							age_q <= age_inc;
							if (expire) begin
								head_q    <= '0;
								tail_q    <= '0;
								fill_q    <= '0;
								wr_left_q <= '0;
								rd_left_q <= '0;
							end
						end
						default: begin
						end
					endcase
				end
				CMD_STEP: begin
					// corrupt header: eviction empties the store, read drops the rest
					if (!hdr_fits) begin
						tail_q <= is_write ? '0 : pos_q;
					end
				end
				CMD_HDR0: begin
					tail_q <= tail_inc;
				end
				CMD_HDR1: begin
					tail_q    <= tail_inc;
					head_q    <= pos_q;
					fill_q    <= f_q + CNT_W'(need);
					wr_left_q <= flen_q;
					age_q     <= '0;
				end
				CMD_FINISH: begin
					fill_q <= f_q;
					if (is_write) begin
						head_q <= pos_q;
						age_q  <= '0;
					end else begin
						rd_left_q <= count_q;
					end
				end
				default: begin
				end
			endcase
			if (cfg_write) begin
				unique case (cfg_index)
					CFG_QUEUE_LENGTH: begin
						ql_q      <= ql_new;
						head_q    <= '0;
						tail_q    <= '0;
						fill_q    <= '0;
						wr_left_q <= '0;
						rd_left_q <= '0;
					end
					CFG_TIMEOUT_TICKS: begin
						tmo_q <= tmo_new;
					end
				endcase
			end
		end
	end

	// transaction payload, walk registers and result fields
	always_ff @(posedge clk) begin
		if (emit) begin
			res_q <= res_n;
		end
		case (cmd)
			CMD_LOAD: begin
				op_q    <= item_data.operation;
				flen_q  <= item_data.frame_length;
				din_q   <= item_data.data_in;
				limit_q <= item_data.read_limit;
			end
			CMD_WALK_INIT: begin
				pos_q     <= head_q;
				f_q       <= fill_q;
				left_q    <= limit_q;
				count_q   <= '0;
				cleared_q <= 1'b0;
			end
			CMD_RD_POS1: begin
				hdr_hi_q <= rdata_q;
			end
			CMD_STEP: begin
				if (hdr_fits) begin
					if (is_write) begin
						// evict the oldest frame
						pos_q <= pos_adv;
						f_q   <= f_q - fl_c;
					end else if (LEN_W'(left_q) >= hdr_len) begin
						// whole frame fits the reader's buffer
						pos_q   <= pos_adv;
						f_q     <= f_q - fl_c;
						count_q <= count_q + fl_c;
						left_q  <= left_q - LIMIT_W'(hdr_len);
					end else begin
						left_q <= '0;
					end
				end else begin
					if (is_write) begin
						pos_q <= '0;
					end
					f_q       <= '0;
					cleared_q <= 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

/* hw/rtl/framed_ring_fifo_drop_oldest.sv */
// byte transactions and ticks latch the item, then load the result once the output is free
// read start below the limit completes directly; otherwise it walks the headers frame by frame
// write start evicts oldest frames until the new one fits, then writes its header; else rejected
// the header walk is bound by the one read port of the ring memory (two byte reads per header)
// reset clears pointers, counts, idle age and result valid; ring contents stay undefined
// no clearing pass: transactions are accepted once reset is released, one in work at a time
module framed_ring_fifo_drop_oldest import frfifo_pkg::*; #(
	parameter int RING_DEPTH = RING_DEPTH_DEFAULT
) (
	input logic              clk,
	input logic              arst_n,
	frfifo_item_if.sink      item,
	frfifo_result_if.source  result,
	frfifo_cfg_if.sink       cfg
);

	cmd_t       cmd;
	dp_status_t st;
	item_t      item_data;
	result_t    res;
	logic       res_valid;
	logic       item_ready;

	// pack the input transaction
	always_comb begin
		item_data.operation    = item.operation;
		item_data.frame_length = item.frame_length;
		item_data.data_in      = item.data_in;
		item_data.read_limit   = item.read_limit;
	end

	assign item.ready = item_ready;
	assign cfg.ready  = 1'b1;

	// controller
	frfifo_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_ready (item_ready),
		.st         (st),
		.cmd        (cmd)
	);

	// datapath
	frfifo_dp #(
		.RING_DEPTH (RING_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.item_data (item_data),
		.cfg_write (cfg.valid),
		.cfg_index (cfg.index),
		.cfg_value (cfg.data),
		.res_ready (result.ready),
		.res_valid (res_valid),
		.res       (res)
	);

	// unpack the result transaction
	assign result.valid         = res_valid;
	assign result.status        = res.status;
	assign result.data_out      = res.data_out;
	assign result.byte_count    = res.byte_count;
	assign result.last_byte     = res.last_byte;
	assign result.store_cleared = res.store_cleared;

`ifndef SYNTHESIS
	// a result is only loaded when the output register is free
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd == CMD_SIMPLE || cmd == CMD_FINISH || cmd == CMD_HDR1) |-> st.out_free)
		else $error("result loaded over a pending transaction");

	// one transaction in work at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(item.valid && item.ready) |=> !item.ready)
		else $error("second transaction accepted while one is in work");

	// a new result only follows a result command
	a_rose_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |->
		$past(cmd == CMD_SIMPLE || cmd == CMD_FINISH || cmd == CMD_HDR1))
		else $error("result valid without a result command");
`endif

endmodule
